FILE: rtl/core/adsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adsr_pkg
// Shared constants for the linear ADSR envelope generator: default widths,
// request and phase codes, register indexes and the duration scale.
// ============================================================================
package adsr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_BITS_DEF = 20;

    // Duration scale in microseconds; durations never exceed it.
    localparam int               DUR_W    = 24;
    localparam logic [DUR_W-1:0] SCALE_US = 24'd10000000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd2;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_ATTACK  = 3'd1;
    localparam logic [2:0] PH_DECAY   = 3'd2;
    localparam logic [2:0] PH_SUSTAIN = 3'd3;
    localparam logic [2:0] PH_RELEASE = 3'd4;
    localparam logic [2:0] PH_ENDED   = 3'd5;

endpackage
`default_nettype wire

FILE: rtl/core/adsr_envelope_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adsr_envelope_generator_core
// Linear ADSR envelope generator with an iterative duration/step datapath.
// ============================================================================
// Usage:
//   s_ channel takes one request per transfer: a tick carrying elapsed
//   microseconds, a note on or a note off. Every request yields exactly one
//   transfer on the m_ channel with the updated level, phase and ended flag.
//   cfg_ channel writes the attack, decay, sustain and release registers;
//   values above full scale are stored as full scale. It is always ready.
//   Timing: a tick in attack, decay or release with a nonzero setting runs
//   square, scale and check, then a bit-serial divide over the
//   TIME_BITS+FRAC_BITS quotient bits, then a done state that registers the
//   result once the output register is free; the next request is taken only
//   after the sequencer is back in idle. A tick whose duration rounds to zero
//   skips the divide; other requests go from square straight to done.
//   s_ready is high only while the sequencer is idle.
//   A result is held in the output register until taken; while m_ready is low
//   the next request may be accepted and computed, and it waits for the
//   output register to free before it commits.
//   Reset clears the envelope to level 0 in idle, sustain to full scale and
//   the time settings to zero.
// ============================================================================
module adsr_envelope_generator_core #(
    parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEF,
    parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [FRAC_BITS:0]               cfg_data,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_req_type,
    input  wire logic [TIME_BITS-1:0]             s_elapsed_us,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [FRAC_BITS:0]                    m_level,
    output logic [2:0]                            m_phase,
    output logic                                  m_ended
);

    localparam int L_W    = FRAC_BITS + 1;
    localparam int Q_W    = TIME_BITS + FRAC_BITS;
    localparam int WIDE_W = Q_W + 1;
    localparam int SQ_W   = 2 * L_W;
    localparam int PROD_W = SQ_W + adsr_pkg::DUR_W;
    localparam int DUR_W  = adsr_pkg::DUR_W;

    localparam logic [L_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SQ    = 6'b000010,
        ST_SCALE = 6'b000100,
        ST_CHK   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [L_W-1:0]       attack_reg, decay_reg, sustain_reg, release_reg;
    logic [L_W-1:0]       cfg_clamped;

    logic [L_W-1:0]       env_level_reg, env_level_next;
    logic [2:0]           env_phase_reg, env_phase_next;

    logic [1:0]           req_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic                 jump_reg, jump_next;
    logic [SQ_W-1:0]      sq_reg;
    logic [DUR_W-1:0]     dur_reg;
    logic [PROD_W-1:0]    prod;

    logic                 m_valid_reg;
    logic [L_W-1:0]       m_level_reg;
    logic [2:0]           m_phase_reg;
    logic                 m_ended_reg;

    logic [L_W-1:0]       p_sel;
    logic                 seg_active;
    logic                 div_start;
    logic                 div_done;
    logic [Q_W-1:0]       div_quot;
    logic [Q_W-1:0]       div_num;
    logic                 out_free;
    logic                 s_xfer;

    logic [WIDE_W-1:0]    inc_w;
    logic [WIDE_W-1:0]    level_w;
    logic [WIDE_W-1:0]    sum_w;
    logic [WIDE_W-1:0]    gap_w;
    logic [L_W-1:0]       gap;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg_ready   = 1'b1;
    assign cfg_clamped = (cfg_data > ONE) ? ONE : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= '0;
            decay_reg   <= '0;
            sustain_reg <= ONE;
            release_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                adsr_pkg::CFG_ATTACK:  attack_reg  <= cfg_clamped;
                adsr_pkg::CFG_DECAY:   decay_reg   <= cfg_clamped;
                adsr_pkg::CFG_SUSTAIN: sustain_reg <= cfg_clamped;
                adsr_pkg::CFG_RELEASE: release_reg <= cfg_clamped;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Segment select
    // ------------------------------------------------------------------
    always_comb begin
        case (env_phase_reg)
            adsr_pkg::PH_ATTACK:  p_sel = attack_reg;
            adsr_pkg::PH_DECAY:   p_sel = decay_reg;
            adsr_pkg::PH_RELEASE: p_sel = release_reg;
            default:              p_sel = '0;
        endcase
    end

    assign seg_active = (req_reg == adsr_pkg::REQ_TICK) &&
                        (env_phase_reg inside {adsr_pkg::PH_ATTACK, adsr_pkg::PH_DECAY,
                                               adsr_pkg::PH_RELEASE});

    assign prod      = PROD_W'(sq_reg) * PROD_W'(adsr_pkg::SCALE_US);
    assign div_num   = {elapsed_reg, {FRAC_BITS{1'b0}}};
    assign div_start = (state_reg == ST_CHK) && (dur_reg != '0);

    adsr_div #(
        .NUM_W (Q_W),
        .DEN_W (DUR_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (dur_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ------------------------------------------------------------------
    // Envelope update
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;

    always_comb begin
        inc_w   = {1'b0, div_quot};
        level_w = {{(WIDE_W-L_W){1'b0}}, env_level_reg};
        sum_w   = level_w + inc_w;
        gap     = env_level_reg - sustain_reg;
        gap_w   = {{(WIDE_W-L_W){1'b0}}, gap};

        env_level_next = env_level_reg;
        env_phase_next = env_phase_reg;

        case (req_reg)
            adsr_pkg::REQ_TICK: begin
                case (env_phase_reg)
                    adsr_pkg::PH_ATTACK: begin
                        if (jump_reg || sum_w >= {{(WIDE_W-L_W){1'b0}}, ONE}) begin
                            env_level_next = ONE;
                            env_phase_next = adsr_pkg::PH_DECAY;
                        end else begin
                            env_level_next = sum_w[L_W-1:0];
                        end
                    end
                    adsr_pkg::PH_DECAY: begin
                        if (jump_reg || env_level_reg <= sustain_reg || inc_w >= gap_w) begin
                            env_level_next = sustain_reg;
                            env_phase_next = adsr_pkg::PH_SUSTAIN;
                        end else begin
                            env_level_next = env_level_reg - div_quot[L_W-1:0];
                        end
                    end
                    adsr_pkg::PH_SUSTAIN: begin
                        env_level_next = sustain_reg;
                    end
                    adsr_pkg::PH_RELEASE: begin
                        if (jump_reg || inc_w >= level_w) begin
                            env_level_next = '0;
                            env_phase_next = adsr_pkg::PH_ENDED;
                        end else begin
                            env_level_next = env_level_reg - div_quot[L_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            adsr_pkg::REQ_NOTE_ON: begin
                env_level_next = '0;
                env_phase_next = adsr_pkg::PH_ATTACK;
            end
            adsr_pkg::REQ_NOTE_OFF: begin
                if (env_phase_reg != adsr_pkg::PH_IDLE &&
                    env_phase_reg != adsr_pkg::PH_ENDED) begin
                    env_phase_next = adsr_pkg::PH_RELEASE;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        jump_next  = jump_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                jump_next = (p_sel == '0);
                if (seg_active && p_sel != '0) begin
                    state_next = ST_SCALE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCALE: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (dur_reg == '0) begin
                    jump_next  = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            env_level_reg <= '0;
            env_phase_reg <= adsr_pkg::PH_IDLE;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                env_level_reg <= env_level_next;
                env_phase_reg <= env_phase_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        jump_reg <= jump_next;
        if (s_xfer) begin
            req_reg     <= s_req_type;
            elapsed_reg <= s_elapsed_us;
        end
        if (state_reg == ST_SQ) begin
            sq_reg <= SQ_W'(p_sel) * SQ_W'(p_sel);
        end
        if (state_reg == ST_SCALE) begin
            dur_reg <= prod[2*FRAC_BITS +: DUR_W];
        end
        if (state_reg == ST_DONE && out_free) begin
            m_level_reg <= env_level_next;
            m_phase_reg <= env_phase_next;
            m_ended_reg <= (env_phase_next == adsr_pkg::PH_ENDED);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;
    assign m_phase = m_phase_reg;
    assign m_ended = m_ended_reg;

endmodule
`default_nettype wire

FILE: rtl/core/adsr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adsr_div
// Iterative restoring divider, one quotient bit per cycle. A start pulse
// loads the operands; done pulses for one cycle when quot is final.
// ============================================================================
module adsr_div #(
    parameter int NUM_W = adsr_pkg::FRAC_BITS_DEF + adsr_pkg::TIME_BITS_DEF,
    parameter int DEN_W = adsr_pkg::DUR_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial     = {rem_reg, quot_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quot_next = {quot_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && run_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (run_reg) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

FILE: test/adsr_envelope_generator_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// adsr_envelope_generator_core_test
// Self-checking bench for the linear ADSR envelope core. A queue-fed driver
// sends ticks, note on, note off and unknown requests. A predictor tracks
// level and phase under the current register settings, and a monitor checks
// every m_ transfer against it. Directed corner cases come first, then random
// note sequences under several settings, with random idling on both sides and
// long output stalls.
// ============================================================================
module adsr_envelope_generator_core_test;

    localparam int FW = adsr_pkg::FRAC_BITS_DEF;
    localparam int TW = adsr_pkg::TIME_BITS_DEF;
    localparam logic [FW:0]   FULL_SCALE  = {1'b1, {FW{1'b0}}};
    localparam logic [FW:0]   OVER_SCALE  = {(FW + 1){1'b1}};
    localparam logic [TW-1:0] MAX_ELAPSED = {TW{1'b1}};
    localparam logic [1:0]    REQ_UNKNOWN = 2'd3;
    localparam int unsigned   LONG_HOLD   = 300;
    localparam int unsigned   STALL_LIMIT = 2000;
    localparam int unsigned   TAIL_CYCLES = 50;

    typedef struct packed {
        logic [1:0]    req;
        logic [TW-1:0] elapsed;
    } request_t;

    typedef struct packed {
        logic [FW:0] level;
        logic [2:0]  phase;
        logic        ended;
    } envelope_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [FW:0]                    cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [1:0]                     s_req_type = '0;
    logic [TW-1:0]                  s_elapsed_us = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [FW:0]                    m_level;
    logic [2:0]                     m_phase;
    logic                           m_ended;

    request_t  request_backlog[$];
    envelope_t envelope_due[$];

    // predictor state
    logic [FW:0] attack_set;
    logic [FW:0] decay_set;
    logic [FW:0] sustain_set;
    logic [FW:0] release_set;
    logic [FW:0] tracked_level;
    logic [2:0]  tracked_phase;

    logic        in_fire = 1'b0;
    logic        out_fire = 1'b0;
    logic        steady = 1'b0;
    int unsigned send_gap = 0;
    int unsigned take_gap = 0;
    int unsigned hold_left = 0;
    int unsigned next_hold = 200;
    int unsigned holds_done = 0;
    int unsigned queued = 0;
    int unsigned accepted = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles = 0;

    adsr_envelope_generator_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_elapsed_us (s_elapsed_us),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_level      (m_level),
        .m_phase      (m_phase),
        .m_ended      (m_ended)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor
    function automatic void reset_tracking();
        attack_set    = '0;
        decay_set     = '0;
        sustain_set   = FULL_SCALE;
        release_set   = '0;
        tracked_level = '0;
        tracked_phase = adsr_pkg::PH_IDLE;
    endfunction

    function automatic void store_setting(input logic [adsr_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [FW:0] val);
        logic [FW:0] v;
        v = (val > FULL_SCALE) ? FULL_SCALE : val;
        case (idx)
            adsr_pkg::CFG_ATTACK:  attack_set = v;
            adsr_pkg::CFG_DECAY:   decay_set = v;
            adsr_pkg::CFG_SUSTAIN: sustain_set = v;
            adsr_pkg::CFG_RELEASE: release_set = v;
            default: ;
        endcase
    endfunction

    // segment length in microseconds: floor(scale * p^2 / 2^(2*FW))
    function automatic logic [63:0] segment_us(input logic [FW:0] p);
        logic [63:0] p64;
        p64 = 64'(p);
        return (p64 * p64 * 64'(adsr_pkg::SCALE_US)) >> (2 * FW);
    endfunction

    // returns 1 when the segment jumps straight to its target
    function automatic logic segment_step(input logic [FW:0] p, input logic [TW-1:0] el,
                                          output logic [63:0] inc);
        logic [63:0] dur;
        inc = '0;
        dur = segment_us(p);
        if (p == '0 || dur == '0)
            return 1'b1;
        inc = (64'(el) << FW) / dur;
        return 1'b0;
    endfunction

    function automatic envelope_t predict_envelope(input request_t rq);
        logic [63:0] lvl;
        logic [63:0] sus;
        logic [63:0] inc;
        logic        jump;
        envelope_t   res;
        lvl = 64'(tracked_level);
        sus = 64'(sustain_set);
        case (rq.req)
            adsr_pkg::REQ_TICK: begin
                case (tracked_phase)
                    adsr_pkg::PH_ATTACK: begin
                        jump = segment_step(attack_set, rq.elapsed, inc);
                        if (jump || lvl + inc >= 64'(FULL_SCALE)) begin
                            lvl = 64'(FULL_SCALE);
                            tracked_phase = adsr_pkg::PH_DECAY;
                        end else begin
                            lvl = lvl + inc;
                        end
                    end
                    adsr_pkg::PH_DECAY: begin
                        jump = segment_step(decay_set, rq.elapsed, inc);
                        if (jump || lvl <= sus || inc >= lvl - sus) begin
                            lvl = sus;
                            tracked_phase = adsr_pkg::PH_SUSTAIN;
                        end else begin
                            lvl = lvl - inc;
                        end
                    end
                    adsr_pkg::PH_SUSTAIN: lvl = sus;
                    adsr_pkg::PH_RELEASE: begin
                        jump = segment_step(release_set, rq.elapsed, inc);
                        if (jump || inc >= lvl) begin
                            lvl = '0;
                            tracked_phase = adsr_pkg::PH_ENDED;
                        end else begin
                            lvl = lvl - inc;
                        end
                    end
                    default: ;
                endcase
            end
            adsr_pkg::REQ_NOTE_ON: begin
                lvl = '0;
                tracked_phase = adsr_pkg::PH_ATTACK;
            end
            adsr_pkg::REQ_NOTE_OFF: begin
                if (tracked_phase != adsr_pkg::PH_IDLE &&
                    tracked_phase != adsr_pkg::PH_ENDED)
                    tracked_phase = adsr_pkg::PH_RELEASE;
            end
            default: ;
        endcase
        tracked_level = lvl[FW:0];
        res.level = tracked_level;
        res.phase = tracked_phase;
        res.ended = (tracked_phase == adsr_pkg::PH_ENDED);
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus
    function automatic int unsigned pick_gap();
        int unsigned k;
        if (steady)
            return 0;
        k = $urandom_range(0, 9);
        if (k < 6)
            return 0;
        if (k < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    function automatic logic [TW-1:0] pick_elapsed();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 4)
            return TW'($urandom_range(0, 255));
        if (k < 7)
            return TW'($urandom_range(0, 4095));
        if (k < 9)
            return TW'($urandom_range(0, 65535));
        return TW'($urandom);
    endfunction

    function automatic logic [FW:0] pick_time_setting();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k < 3)
            return '0;
        if (k < 6)
            return (FW + 1)'($urandom_range(1, 20));
        if (k < 14)
            return (FW + 1)'($urandom_range(50, 3000));
        if (k < 18)
            return (FW + 1)'($urandom_range(3001, 65536));
        return (FW + 1)'($urandom_range(65537, 131071));
    endfunction

    function automatic logic [FW:0] pick_sustain();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return '0;
        if (k == 1)
            return FULL_SCALE;
        if (k == 2)
            return (FW + 1)'($urandom_range(65537, 131071));
        return (FW + 1)'($urandom_range(0, 65536));
    endfunction

    task automatic queue_req(input logic [1:0] req, input logic [TW-1:0] el);
        request_t rq;
        rq.req = req;
        rq.elapsed = el;
        request_backlog.push_back(rq);
        if (req != REQ_UNKNOWN)
            queued++;
    endtask

    task automatic queue_random(input int unsigned target);
        int unsigned stop_at;
        int unsigned n;
        stop_at = queued + target;
        while (queued < stop_at) begin
            if ($urandom_range(0, 99) < 85) begin
                queue_req(adsr_pkg::REQ_NOTE_ON, TW'($urandom));
                n = $urandom_range(1, 8);
                repeat (n) queue_req(adsr_pkg::REQ_TICK, pick_elapsed());
                if ($urandom_range(0, 4) != 0)
                    queue_req(adsr_pkg::REQ_NOTE_OFF, TW'($urandom));
                n = $urandom_range(1, 8);
                repeat (n) queue_req(adsr_pkg::REQ_TICK, pick_elapsed());
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) queue_req(2'($urandom_range(0, 3)), TW'($urandom));
            end
        end
    endtask

    task automatic write_reg(input logic [adsr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [FW:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (request_backlog.size() != 0 || s_valid || envelope_due.size() != 0);
    endtask

    task automatic configure(input int unsigned round);
        settings_used++;
        if (round == 0) begin
            write_reg(adsr_pkg::CFG_ATTACK, OVER_SCALE);
            write_reg(adsr_pkg::CFG_DECAY, OVER_SCALE);
            write_reg(adsr_pkg::CFG_SUSTAIN, OVER_SCALE);
            write_reg(adsr_pkg::CFG_RELEASE, OVER_SCALE);
        end else if (round == 1) begin
            write_reg(adsr_pkg::CFG_ATTACK, '0);
            write_reg(adsr_pkg::CFG_DECAY, '0);
            write_reg(adsr_pkg::CFG_SUSTAIN, '0);
            write_reg(adsr_pkg::CFG_RELEASE, '0);
        end else begin
            write_reg(adsr_pkg::CFG_ATTACK, pick_time_setting());
            write_reg(adsr_pkg::CFG_DECAY, pick_time_setting());
            write_reg(adsr_pkg::CFG_SUSTAIN, pick_sustain());
            write_reg(adsr_pkg::CFG_RELEASE, pick_time_setting());
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     results_seen, what, got, want);
    endtask

    // ---------------------------------------------------------------- processes
    always @(posedge aclk) begin : accept
        request_t rq;
        if (!aresetn) begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
            reset_tracking();
        end else begin
            in_fire  <= s_valid && s_ready;
            out_fire <= m_valid && m_ready;
            if (cfg_valid && cfg_ready)
                store_setting(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                rq.req = s_req_type;
                rq.elapsed = s_elapsed_us;
                envelope_due.push_back(predict_envelope(rq));
                accepted++;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        envelope_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (envelope_due.size() == 0) begin
                report_mismatch("unexpected transfer, level", 32'(m_level), 0);
            end else begin
                want = envelope_due.pop_front();
                if (m_level != want.level)
                    report_mismatch("level", 32'(m_level), 32'(want.level));
                if (m_phase != want.phase)
                    report_mismatch("phase", 32'(m_phase), 32'(want.phase));
                if (m_ended != want.ended)
                    report_mismatch("ended", 32'(m_ended), 32'(want.ended));
            end
        end
    end

    always @(negedge aclk) begin : driver
        request_t rq;
        if (aresetn && (!s_valid || in_fire)) begin
            if (send_gap != 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (request_backlog.size() != 0) begin
                rq = request_backlog.pop_front();
                s_valid      <= 1'b1;
                s_req_type   <= rq.req;
                s_elapsed_us <= rq.elapsed;
                send_gap     <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : receiver
        if (aresetn) begin
            if (hold_left != 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (results_seen >= next_hold) begin
                m_ready    <= 1'b0;
                hold_left  <= LONG_HOLD;
                next_hold  <= next_hold + 500;
                holds_done <= holds_done + 1;
            end else if (take_gap != 0) begin
                m_ready  <= 1'b0;
                take_gap <= take_gap - 1;
            end else begin
                m_ready <= 1'b1;
                if (out_fire)
                    take_gap <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : main
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: every segment jumps
        queue_req(adsr_pkg::REQ_TICK, MAX_ELAPSED);
        queue_req(adsr_pkg::REQ_NOTE_OFF, '0);
        queue_req(REQ_UNKNOWN, MAX_ELAPSED);
        queue_req(adsr_pkg::REQ_NOTE_ON, MAX_ELAPSED);
        queue_req(adsr_pkg::REQ_TICK, '0);
        queue_req(adsr_pkg::REQ_TICK, MAX_ELAPSED);
        queue_req(adsr_pkg::REQ_TICK, TW'(1));
        queue_req(adsr_pkg::REQ_NOTE_OFF, MAX_ELAPSED);
        queue_req(adsr_pkg::REQ_NOTE_OFF, '0);
        queue_req(adsr_pkg::REQ_TICK, '0);
        queue_req(adsr_pkg::REQ_TICK, MAX_ELAPSED);
        queue_req(adsr_pkg::REQ_NOTE_OFF, '0);
        queue_req(REQ_UNKNOWN, '0);
        wait_drained();

        // slowest segments, zero-length release
        settings_used++;
        write_reg(adsr_pkg::CFG_ATTACK, FULL_SCALE);
        write_reg(adsr_pkg::CFG_DECAY, FULL_SCALE);
        write_reg(adsr_pkg::CFG_SUSTAIN, FULL_SCALE >> 1);
        write_reg(adsr_pkg::CFG_RELEASE, (FW + 1)'(20));
        queue_req(adsr_pkg::REQ_NOTE_ON, '0);
        queue_req(adsr_pkg::REQ_TICK, MAX_ELAPSED);
        queue_req(adsr_pkg::REQ_TICK, '0);
        queue_req(adsr_pkg::REQ_TICK, TW'(1));
        wait_drained();

        // one-microsecond attack finishes, decay starts
        write_reg(adsr_pkg::CFG_ATTACK, (FW + 1)'(21));
        queue_req(adsr_pkg::REQ_TICK, TW'(5));
        queue_req(adsr_pkg::REQ_TICK, MAX_ELAPSED);
        wait_drained();

        // sustain raised above the decaying level
        write_reg(adsr_pkg::CFG_SUSTAIN, (FW + 1)'(60000));
        queue_req(adsr_pkg::REQ_TICK, '0);
        wait_drained();

        write_reg(adsr_pkg::CFG_SUSTAIN, OVER_SCALE);
        queue_req(adsr_pkg::REQ_TICK, TW'(3));
        queue_req(adsr_pkg::REQ_NOTE_OFF, '0);
        wait_drained();

        write_reg(adsr_pkg::CFG_RELEASE, (FW + 1)'(FULL_SCALE - 1));
        queue_req(adsr_pkg::REQ_TICK, MAX_ELAPSED);
        queue_req(adsr_pkg::REQ_NOTE_ON, '0);
        wait_drained();

        for (int unsigned round = 0; round < 8; round++) begin
            steady = (round % 3 == 2);
            configure(round);
            queue_random(125);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (envelope_due.size() != 0)
            report_mismatch("results still owed", envelope_due.size(), 0);

        $display("covered %0d requests and %0d results over %0d register settings",
                 accepted, results_seen, settings_used);
        $display("long output stalls: %0d, mismatches: %0d", holds_done, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/adsr_pkg.sv
rtl/core/adsr_div.sv
rtl/core/adsr_envelope_generator_core.sv
test/adsr_envelope_generator_core_test.sv
